FILE: rtl/core/edfq_pkg.sv
`default_nettype none
package edfq_pkg;

	localparam int DL_W        = 32;
	localparam int ID_W        = 8;
	localparam int PRIO_W      = 8;
	localparam int ENTRY_W     = 5;
	localparam int MAX_RESULTS = 16;
	localparam int POP_W       = $clog2(MAX_RESULTS);
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [PRIO_W-1:0] BASE_PRIO_RST = PRIO_W'(1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_EXPIRE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_NONE_DUE  = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// register index of the base priority
	localparam logic REG_BASE_PRIO = 1'b0;

	// command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
		logic pop;
	} cell_cmd_t;

	// per-cell status seen by the controller
	typedef struct packed {
		logic gt;
		logic seen;
		logic take_new;
		logic first_hit;
	} cell_flag_t;

endpackage
`default_nettype wire

FILE: rtl/core/edfq_req_if.sv
`default_nettype none
interface edfq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  task_id;
	logic [31:0] deadline;
	logic [31:0] current_time;

	modport source (output valid, output opcode, output task_id, output deadline,
		output current_time, input ready);
	modport sink (input valid, input opcode, input task_id, input deadline,
		input current_time, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/edfq_rsp_if.sv
`default_nettype none
interface edfq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  out_task_id;
	logic [31:0] out_deadline;
	logic [7:0]  priority_res;
	logic [4:0]  entry_count;
	logic        last;

	modport source (output valid, output status, output out_task_id, output out_deadline,
		output priority_res, output entry_count, output last, input ready);
	modport sink (input valid, input status, input out_task_id, input out_deadline,
		input priority_res, input entry_count, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/edf_deadline_queue_unit.sv
// Insert and remove: the request is latched, then every cell compares and shifts
// while the result is registered; a response not yet taken by the sink holds that step.
// Expire: one result per cycle while the sink takes each response, the head popping one step
// each time; up to 16 results per transaction. A new transaction is taken in the cycle after
// the final result is registered.
// Asynchronous active-low reset empties the queue and sets the base priority to 1.
`default_nettype none
module edf_deadline_queue_unit #(
	parameter int CAPACITY = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	edfq_req_if.sink                             req,
	edfq_rsp_if.source                           rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [edfq_pkg::APB_AW-1:0]     paddr,
	input  wire logic [edfq_pkg::APB_DW-1:0]     pwdata,
	output logic [edfq_pkg::APB_DW-1:0]          prdata,
	output logic                                 pready
);
	import edfq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t            state_q, state_d;
	op_t               op_q;
	logic [ID_W-1:0]   id_q;
	logic [DL_W-1:0]   dl_q;
	logic [DL_W-1:0]   now_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [POP_W-1:0]  pop_cnt_q, pop_cnt_d;
	logic [PRIO_W-1:0] base_prio_q;

	logic              rsp_valid_q;
	status_t           status_q, status_d;
	logic [ID_W-1:0]   rsp_id_q, rsp_id_d;
	logic [DL_W-1:0]   rsp_dl_q, rsp_dl_d;
	logic [PRIO_W-1:0] rsp_prio_q, rsp_prio_d;
	logic [ENTRY_W-1:0] rsp_cnt_q, rsp_cnt_d;
	logic              rsp_last_q, rsp_last_d;
	logic              load_out;
	logic              can_emit;
	cell_cmd_t         cmd;

	logic [DL_W-1:0]   cell_dl  [CAPACITY];
	logic [ID_W-1:0]   cell_id  [CAPACITY];
	cell_flag_t        cell_flg [CAPACITY];
	logic [DL_W-1:0]   l_dl     [CAPACITY];
	logic [ID_W-1:0]   l_id     [CAPACITY];
	logic [DL_W-1:0]   r_dl     [CAPACITY];
	logic [ID_W-1:0]   r_id     [CAPACITY];
	logic              gt_in    [CAPACITY];
	logic              seen_in  [CAPACITY];

	logic [CNT_W-1:0]  ins_pos;
	logic [DL_W-1:0]   rm_dl;
	logic              found;
	logic              full;
	logic              due0, due1, last_pop;
	logic [CNT_W-1:0]  behind;

	// ---- cell row ----
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign l_dl[i]    = '0;
			assign l_id[i]    = '0;
			assign gt_in[i]   = 1'b0;
			assign seen_in[i] = 1'b0;
		end else begin : g_body
			assign l_dl[i]    = cell_dl[i-1];
			assign l_id[i]    = cell_id[i-1];
			assign gt_in[i]   = cell_flg[i-1].gt;
			assign seen_in[i] = cell_flg[i-1].seen;
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign r_dl[i] = '0;
			assign r_id[i] = '0;
		end else begin : g_inner
			assign r_dl[i] = cell_dl[i+1];
			assign r_id[i] = cell_id[i+1];
		end

		edfq_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count_q),
			.new_dl    (dl_q),
			.new_id    (id_q),
			.gt_prev   (gt_in[i]),
			.seen_prev (seen_in[i]),
			.left_dl   (l_dl[i]),
			.left_id   (l_id[i]),
			.right_dl  (r_dl[i]),
			.right_id  (r_id[i]),
			.flag      (cell_flg[i]),
			.dl        (cell_dl[i]),
			.id        (cell_id[i])
		);
	end

	// one-hot flags to insert slot and removed deadline
	always_comb begin
		ins_pos = '0;
		rm_dl   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_flg[i].take_new)
				ins_pos = ins_pos | CNT_W'(i);
			if (cell_flg[i].first_hit)
				rm_dl = rm_dl | cell_dl[i];
		end
	end

	assign found    = cell_flg[CAPACITY-1].seen;
	assign full     = count_q >= CNT_W'(CAPACITY);
	assign behind   = count_q - ins_pos;
	assign due0     = (count_q != '0) && (cell_dl[0] <= now_q);
	assign due1     = (count_q > CNT_W'(1)) && (cell_dl[1] <= now_q);
	assign last_pop = (pop_cnt_q == POP_W'(MAX_RESULTS - 1)) || !due1;
	assign can_emit = !rsp_valid_q || rsp.ready;

	// ---- control ----
	always_comb begin
		state_d    = state_q;
		req.ready  = (state_q == S_IDLE);
		cmd        = '0;
		load_out   = 1'b0;
		count_d    = count_q;
		pop_cnt_d  = pop_cnt_q;
		status_d   = STAT_OK;
		rsp_id_d   = '0;
		rsp_dl_d   = '0;
		rsp_prio_d = '0;
		rsp_cnt_d  = ENTRY_W'(count_q);
		rsp_last_d = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (req.valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				case (op_q)
					OP_INSERT: begin
						if (can_emit) begin
							load_out = 1'b1;
							state_d  = S_IDLE;
							rsp_id_d = id_q;
							rsp_dl_d = dl_q;
							if (full) begin
								status_d = STAT_FULL;
							end else begin
								cmd.ins    = 1'b1;
								count_d    = count_q + 1'b1;
								rsp_prio_d = base_prio_q + PRIO_W'(behind);
								rsp_cnt_d  = ENTRY_W'(count_d);
							end
						end
					end
					OP_REMOVE: begin
						if (can_emit) begin
							load_out = 1'b1;
							state_d  = S_IDLE;
							rsp_id_d = id_q;
							if (found) begin
								cmd.rem   = 1'b1;
								count_d   = count_q - 1'b1;
								rsp_dl_d  = rm_dl;
								rsp_cnt_d = ENTRY_W'(count_d);
							end else begin
								status_d = STAT_NOT_FOUND;
							end
						end
					end
					OP_EXPIRE: begin
						if (can_emit) begin
							load_out = 1'b1;
							if (!due0) begin
								// only reached on the first step: later steps are known due
								status_d  = STAT_NONE_DUE;
								state_d   = S_IDLE;
								pop_cnt_d = '0;
							end else begin
								cmd.pop    = 1'b1;
								count_d    = count_q - 1'b1;
								rsp_id_d   = cell_id[0];
								rsp_dl_d   = cell_dl[0];
								rsp_cnt_d  = ENTRY_W'(count_d);
								rsp_last_d = last_pop;
								if (last_pop) begin
									state_d   = S_IDLE;
									pop_cnt_d = '0;
								end else begin
									pop_cnt_d = pop_cnt_q + 1'b1;
								end
							end
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pop_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
			base_prio_q <= BASE_PRIO_RST;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			pop_cnt_q <= pop_cnt_d;
			if (load_out)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			if (psel && penable && pwrite && pready && (paddr[2] == REG_BASE_PRIO))
				base_prio_q <= pwdata[PRIO_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= op_t'(req.opcode);
			id_q  <= req.task_id;
			dl_q  <= req.deadline;
			now_q <= req.current_time;
		end
		if (load_out) begin
			status_q   <= status_d;
			rsp_id_q   <= rsp_id_d;
			rsp_dl_q   <= rsp_dl_d;
			rsp_prio_q <= rsp_prio_d;
			rsp_cnt_q  <= rsp_cnt_d;
			rsp_last_q <= rsp_last_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_task_id  = rsp_id_q;
	assign rsp.out_deadline = rsp_dl_q;
	assign rsp.priority_res = rsp_prio_q;
	assign rsp.entry_count  = rsp_cnt_q;
	assign rsp.last         = rsp_last_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BASE_PRIO) ? APB_DW'(base_prio_q) : '0;

	// ---- checks ----
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("queue occupancy beyond capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not add an entry");

	a_idle_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pop_cnt_q == '0))
		else $error("expire counter left running in idle");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && rsp_last_d) |=> (state_q == S_IDLE))
		else $error("final result without return to idle");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q != STAT_OK)) |-> rsp_last_q)
		else $error("error transaction not marked last");

endmodule
`default_nettype wire

FILE: rtl/core/edfq_cell.sv
`default_nettype none
module edfq_cell #(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  wire logic                     clk,
	input  wire edfq_pkg::cell_cmd_t      cmd,
	input  wire logic [CNT_W-1:0]         count,
	input  wire logic [edfq_pkg::DL_W-1:0] new_dl,
	input  wire logic [edfq_pkg::ID_W-1:0] new_id,
	input  wire logic                     gt_prev,
	input  wire logic                     seen_prev,
	input  wire logic [edfq_pkg::DL_W-1:0] left_dl,
	input  wire logic [edfq_pkg::ID_W-1:0] left_id,
	input  wire logic [edfq_pkg::DL_W-1:0] right_dl,
	input  wire logic [edfq_pkg::ID_W-1:0] right_id,
	output edfq_pkg::cell_flag_t          flag,
	output logic [edfq_pkg::DL_W-1:0]     dl,
	output logic [edfq_pkg::ID_W-1:0]     id
);
	import edfq_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic [DL_W-1:0] dl_q;
	logic [ID_W-1:0] id_q;
	logic            occ;
	logic            match;

	assign occ   = MY_IDX < count;
	assign match = occ && (id_q == new_id);

	always_comb begin
		flag.gt        = occ && (dl_q > new_dl);
		flag.seen      = seen_prev | match;
		// first later entry, or the free slot when nothing is later
		flag.take_new  = !gt_prev && (flag.gt || (MY_IDX == count));
		flag.first_hit = match && !seen_prev;
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (gt_prev) begin
				dl_q <= left_dl;
				id_q <= left_id;
			end else if (flag.take_new) begin
				dl_q <= new_dl;
				id_q <= new_id;
			end
		end else if (cmd.pop || (cmd.rem && flag.seen)) begin
			dl_q <= right_dl;
			id_q <= right_id;
		end
	end

	assign dl = dl_q;
	assign id = id_q;

endmodule
`default_nettype wire
